>>> rtl/phs_pkg.sv
// Shared constants of the pixel HSV shift block.
`timescale 1ns / 1ps
`default_nettype none
package phs_pkg;

	// Width of the configuration registers and of the register index.
	localparam int REG_W = 14;
	localparam int IDX_W = 2;

	// Register indexes of the configuration port.
	localparam logic [IDX_W-1:0] REG_HUE_SHIFT = 2'd0;
	localparam logic [IDX_W-1:0] REG_SAT_SHIFT = 2'd1;
	localparam logic [IDX_W-1:0] REG_VAL_SHIFT = 2'd2;

	// Sector of the largest channel in the forward conversion.
	typedef enum logic [1:0] {
		SEC_RED   = 2'd0,
		SEC_GREEN = 2'd1,
		SEC_BLUE  = 2'd2
	} max_sec_t;

endpackage
`default_nettype wire

>>> rtl/phs_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module phs_div #(
	parameter int DW = 12,
	parameter int QW = 12
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [DW+QW-1:0] num,
	input  wire logic [DW-1:0]    den,
	output logic      [QW-1:0]    quo
);

	localparam int W = DW + QW;

	// The numerator must stay below den * 2**QW for the quotient to fit.
	logic [W-1:0]  rem_s [QW-1];
	logic [DW-1:0] den_s [QW-1];
	logic [QW-1:0] quo_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [W-1:0]  rem_in;
		logic [DW-1:0] den_in;
		logic [QW-1:0] quo_in;
		logic [W-1:0]  trial;
		logic          take;

		if (k == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign quo_in = quo_s[k-1];
		end

		assign trial = W'(den_in) << (QW - 1 - k);
		assign take  = (rem_in >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[k] <= take ? (quo_in | (QW'(1) << (QW - 1 - k))) : quo_in;
			end
		end

		if (k < QW - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= take ? (rem_in - trial) : rem_in;
					den_s[k] <= den_in;
				end
			end
		end
	end

	assign quo = quo_s[QW-1];

endmodule
`default_nettype wire

>>> rtl/pixel_hsv_shift_core.sv
// Top level of the pixel HSV shift block: RGB to HSV, shift, HSV to RGB.
//
// One RGBA pixel is taken on the s_t* channel and one adjusted pixel leaves on
// the m_t* channel; tdata holds red, green, blue and alpha from the lowest bit.
// Hue, saturation and value shifts are written through cfg_we, cfg_index and
// cfg_data while no pixel is in flight.
// The pipeline takes a pixel in every cycle while s_tready is high. The depth
// is set mostly by the one-bit-per-stage dividers for saturation and hue; the
// p, q and t terms use reciprocal products, with the products and the channel
// order in registered stages of their own.
// When the receiver stalls, the output register holds its pixel and one more
// pixel lands in a skid register; s_tready then drops and the whole pipeline
// holds until the output is taken. Nothing is dropped or repeated.
// Reset clears all valid bits and sets the three shifts to zero.
`timescale 1ns / 1ps
`default_nettype none
module pixel_hsv_shift_core #(
	parameter int CHANNEL_BITS  = 12,
	parameter int HUE_FRAC_BITS = 4
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// red_in, green_in, blue_in, alpha_in from the lowest bit
	input  wire logic [((4*CHANNEL_BITS+7)/8)*8-1:0] s_tdata,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// red_out, green_out, blue_out, alpha_out from the lowest bit
	output logic      [((4*CHANNEL_BITS+7)/8)*8-1:0] m_tdata,
	input  wire logic                           cfg_we,
	input  wire logic [phs_pkg::IDX_W-1:0]      cfg_index,
	input  wire logic [phs_pkg::REG_W-1:0]      cfg_data
);

	localparam int    C      = CHANNEL_BITS;
	localparam int    DATA_W = ((4 * C + 7) / 8) * 8;
	localparam int    CMAX   = (1 << C) - 1;
	localparam int    SECTOR = 60 << HUE_FRAC_BITS;
	localparam int    FULL   = 360 << HUE_FRAC_BITS;
	localparam int    SW     = $clog2(SECTOR + 1);
	localparam int    HW     = $clog2(FULL);
	localparam int    QA     = (C > SW) ? C : SW;
	localparam int    FNW    = C + QA;
	localparam int    BDW    = C + SW;
	localparam int    BNW    = BDW + C;
	localparam longint DENQ  = longint'(CMAX) * longint'(SECTOR);
	localparam int    REG_W  = phs_pkg::REG_W;
	localparam int    HSW    = ((HW > REG_W) ? HW : REG_W) + 3;
	localparam int    SVW    = ((QA > REG_W) ? QA : REG_W) + 2;
	localparam int    NST    = QA + 8;

	// Reciprocals for the divisions by CMAX and by CMAX * SECTOR. The second
	// one drops the power of two inside SECTOR with a shift first.
	localparam int     PNW = 2 * C;
	localparam int     PK  = PNW + C;
	localparam int     PMW = PNW + 1;
	localparam longint PM  = ((longint'(1) << PK) + longint'(CMAX) - 1) / longint'(CMAX);
	localparam int     SH  = HUE_FRAC_BITS + 2;
	localparam longint DQ  = DENQ >> SH;
	localparam int     QNW = BNW - SH;
	localparam int     QK  = QNW + $clog2(DQ);
	localparam int     QMW = QNW + 1;
	localparam longint QM  = ((longint'(1) << QK) + DQ - 1) / DQ;

	localparam logic signed [HSW-1:0] FULL_S = HSW'(FULL);

	typedef struct packed {
		logic [C-1:0]      mx;
		logic [C-1:0]      alpha;
		phs_pkg::max_sec_t sec;
		logic              neg;
		logic              grey;
	} fside_t;

	typedef struct packed {
		logic [2:0]   sect;
		logic [C-1:0] v;
		logic [C-1:0] alpha;
	} bside_t;

	function automatic logic [C-1:0] clamp_chan(input logic signed [SVW-1:0] x);
		if (x < 0)
			return '0;
		if (x > SVW'(CMAX))
			return C'(CMAX);
		return x[C-1:0];
	endfunction

	// Configuration registers.
	logic signed [REG_W-1:0] hue_q, sat_q, val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_q <= '0;
			sat_q <= '0;
			val_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				phs_pkg::REG_HUE_SHIFT: hue_q <= cfg_data;
				phs_pkg::REG_SAT_SHIFT: sat_q <= cfg_data;
				phs_pkg::REG_VAL_SHIFT: val_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pipeline control: every stage moves when the skid register is empty.
	logic            adv;
	logic [NST-1:0]  vld_q;
	logic            out_v_q, skid_v_q;
	logic [DATA_W-1:0] out_q, skid_q, sel_word;

	assign adv      = !skid_v_q;
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NST-2:0], s_tvalid};
		end
	end

	// Prep stage: max, min, sector and the two dividends.
	logic [C-1:0]      r_c, g_c, b_c, a_c, mx_c, mn_c, d_c, hi_c, lo_c, mag_c;
	phs_pkg::max_sec_t sec_c;
	logic [FNW-1:0]    n1_c, n2_c;

	always_comb begin
		r_c = s_tdata[C-1:0];
		g_c = s_tdata[2*C-1:C];
		b_c = s_tdata[3*C-1:2*C];
		a_c = s_tdata[4*C-1:3*C];
		mx_c = r_c;
		mn_c = r_c;
		if (g_c > mx_c) mx_c = g_c;
		if (b_c > mx_c) mx_c = b_c;
		if (g_c < mn_c) mn_c = g_c;
		if (b_c < mn_c) mn_c = b_c;
		d_c = mx_c - mn_c;
		if (r_c == mx_c) begin
			sec_c = phs_pkg::SEC_RED;
			hi_c  = g_c;
			lo_c  = b_c;
		end else if (g_c == mx_c) begin
			sec_c = phs_pkg::SEC_GREEN;
			hi_c  = b_c;
			lo_c  = r_c;
		end else begin
			sec_c = phs_pkg::SEC_BLUE;
			hi_c  = r_c;
			lo_c  = g_c;
		end
		mag_c = (hi_c >= lo_c) ? (hi_c - lo_c) : (lo_c - hi_c);
		n1_c  = (FNW'(d_c) << C) - FNW'(d_c) + FNW'(mx_c >> 1);
		n2_c  = FNW'(SECTOR) * FNW'(mag_c) + FNW'(d_c >> 1);
	end

	logic [FNW-1:0] n1_s1, n2_s1;
	logic [C-1:0]   d_s1;
	fside_t         side_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			n1_s1         <= n1_c;
			n2_s1         <= n2_c;
			d_s1          <= d_c;
			side_s1.mx    <= mx_c;
			side_s1.alpha <= a_c;
			side_s1.sec   <= sec_c;
			side_s1.neg   <= (hi_c < lo_c);
			side_s1.grey  <= (d_c == '0);
		end
	end

	// Forward dividers: saturation and hue within the sector.
	logic [QA-1:0] q_sat, q_hue;
	fside_t        fside_s [QA];

	phs_div #(.DW(C), .QW(QA)) u_div_sat (
		.clk (clk), .en (adv), .num (n1_s1), .den (side_s1.mx), .quo (q_sat)
	);

	phs_div #(.DW(C), .QW(QA)) u_div_hue (
		.clk (clk), .en (adv), .num (n2_s1), .den (d_s1), .quo (q_hue)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			fside_s[0] <= side_s1;
			for (int k = 1; k < QA; k++)
				fside_s[k] <= fside_s[k-1];
		end
	end

	// Stage 2: raw hue plus the hue shift, saturation and value shifts.
	fside_t                  fs;
	logic signed [HSW-1:0]   hb_c, hq_c, h0_c;
	logic signed [SVW-1:0]   ssum_c, vsum_c;

	assign fs = fside_s[QA-1];

	always_comb begin
		unique case (fs.sec)
			phs_pkg::SEC_GREEN: hb_c = HSW'(2 * SECTOR);
			phs_pkg::SEC_BLUE:  hb_c = HSW'(4 * SECTOR);
			default:            hb_c = '0;
		endcase
		hq_c = $signed(HSW'(q_hue));
		h0_c = fs.neg ? (hb_c - hq_c) : (hb_c + hq_c);
		if (h0_c < 0)
			h0_c = h0_c + FULL_S;
		ssum_c = $signed(SVW'(q_sat)) + SVW'(sat_q);
		vsum_c = $signed(SVW'(fs.mx)) + SVW'(val_q);
	end

	logic signed [HSW-1:0] h_s2;
	logic [C-1:0]          s_s2, v_s2, a_s2;
	logic                  grey_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			h_s2    <= h0_c + HSW'(hue_q);
			s_s2    <= fs.grey ? '0 : clamp_chan(ssum_c);
			v_s2    <= clamp_chan(vsum_c);
			a_s2    <= fs.alpha;
			grey_s2 <= fs.grey;
		end
	end

	// Stage 3: two wrap steps in each direction bring the hue into one turn.
	logic signed [HSW-1:0] w_c;

	always_comb begin
		w_c = h_s2;
		for (int k = 0; k < 2; k++) begin
			if (w_c < 0)
				w_c = w_c + FULL_S;
			if (w_c >= FULL_S)
				w_c = w_c - FULL_S;
		end
	end

	logic [HW-1:0] h_s3;
	logic [C-1:0]  s_s3, v_s3, a_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			h_s3 <= grey_s2 ? '0 : w_c[HW-1:0];
			s_s3 <= s_s2;
			v_s3 <= v_s2;
			a_s3 <= a_s2;
		end
	end

	// Stage 4: sector index and offset within the sector.
	logic [2:0]    sect_c;
	logic [HW-1:0] foff_c;

	always_comb begin
		sect_c = '0;
		for (int k = 1; k < 6; k++) begin
			if (h_s3 >= HW'(k * SECTOR))
				sect_c = 3'(k);
		end
		foff_c = h_s3 - HW'(sect_c) * HW'(SECTOR);
	end

	logic [2:0]    sect_s4;
	logic [SW-1:0] f_s4;
	logic [C-1:0]  s_s4, v_s4, a_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			sect_s4 <= sect_c;
			f_s4    <= foff_c[SW-1:0];
			s_s4    <= s_s3;
			v_s4    <= v_s3;
			a_s4    <= a_s3;
		end
	end

	// Stage 5: saturation times the sector offset and its complement.
	logic [BDW-1:0] sf_s5, st_s5;
	logic [2:0]     sect_s5;
	logic [C-1:0]   s_s5, v_s5, a_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			sf_s5   <= BDW'(s_s4) * BDW'(f_s4);
			st_s5   <= BDW'(s_s4) * BDW'(SW'(SECTOR) - f_s4);
			sect_s5 <= sect_s4;
			s_s5    <= s_s4;
			v_s5    <= v_s4;
			a_s5    <= a_s4;
		end
	end

	// Stage 6: rounded dividends of p, q and t.
	logic [PNW-1:0] pn_s6;
	logic [BNW-1:0] qn_s6, tn_s6;
	bside_t         bsd_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			pn_s6 <= (2*C)'(v_s5) * (2*C)'(C'(CMAX) - s_s5) + (2*C)'(CMAX >> 1);
			qn_s6 <= BNW'(v_s5) * (BNW'(DENQ) - BNW'(sf_s5)) + BNW'(DENQ >> 1);
			tn_s6 <= BNW'(v_s5) * (BNW'(DENQ) - BNW'(st_s5)) + BNW'(DENQ >> 1);
			bsd_s6.sect  <= sect_s5;
			bsd_s6.v     <= v_s5;
			bsd_s6.alpha <= a_s5;
		end
	end

	// Stage 7: products with the rounded-up reciprocals of the constant scales.
	logic [PNW+PMW-1:0] pp_s7;
	logic [QNW+QMW-1:0] qp_s7, tp_s7;
	bside_t             bsd_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			pp_s7  <= (PNW+PMW)'(pn_s6) * (PNW+PMW)'(PM);
			qp_s7  <= (QNW+QMW)'(qn_s6[BNW-1:SH]) * (QNW+QMW)'(QM);
			tp_s7  <= (QNW+QMW)'(tn_s6[BNW-1:SH]) * (QNW+QMW)'(QM);
			bsd_s7 <= bsd_s6;
		end
	end

	// Stage 8: pick the channel order of the sector.
	bside_t       bs;
	logic [C-1:0] p_c, q_c, t_c, ro_c, go_c, bo_c;

	assign bs  = bsd_s7;
	assign p_c = pp_s7[PK +: C];
	assign q_c = qp_s7[QK +: C];
	assign t_c = tp_s7[QK +: C];

	always_comb begin
		case (bs.sect)
			3'd0: begin ro_c = bs.v; go_c = t_c;  bo_c = p_c;  end
			3'd1: begin ro_c = q_c;  go_c = bs.v; bo_c = p_c;  end
			3'd2: begin ro_c = p_c;  go_c = bs.v; bo_c = t_c;  end
			3'd3: begin ro_c = p_c;  go_c = q_c;  bo_c = bs.v; end
			3'd4: begin ro_c = t_c;  go_c = p_c;  bo_c = bs.v; end
			default: begin ro_c = bs.v; go_c = p_c; bo_c = q_c; end
		endcase
	end

	logic [DATA_W-1:0] pix_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s8 <= DATA_W'({bs.alpha, bo_c, go_c, ro_c});
		end
	end

	assign sel_word = pix_s8;

	// Output register with one skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (m_tready) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end
		end else if (!out_v_q || m_tready) begin
			out_v_q <= vld_q[NST-1];
		end else if (vld_q[NST-1]) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (m_tready)
				out_q <= skid_q;
		end else if (!out_v_q || m_tready) begin
			out_q <= sel_word;
		end else begin
			skid_q <= sel_word;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

endmodule
`default_nettype wire

>>> rtl/phs_checker.sv
// Port-level checks of the pixel HSV shift block and their bind.
`timescale 1ns / 1ps
`default_nettype none
module phs_checker #(
	parameter int DATA_W = 48
) (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              s_tready,
	input wire logic              m_tvalid,
	input wire logic              m_tready,
	input wire logic [DATA_W-1:0] m_tdata
);

	// A stalled result keeps its data.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output changed while stalled");

	// Input back-pressure only appears with a result waiting at the output.
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result waiting");

	// Back-pressure starts only after the receiver refused a result.
	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(m_tvalid && !m_tready))
		else $error("input stalled without an output stall");

	// Back-pressure clears only when the receiver takes a result.
	a_ready_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(s_tready) |-> $past(m_tready))
		else $error("input released without an output transfer");

endmodule

bind pixel_hsv_shift_core phs_checker #(.DATA_W(DATA_W)) u_phs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire
